// ===== src/dgbd_pkg.sv =====
// Shared constants, types and trig tables for the direction grid block downsampler.
`default_nettype none

package dgbd_pkg;

	// Cell codes
	localparam logic signed [7:0] CODE_OBSTACLE    = 8'sd100;
	localparam logic signed [7:0] CODE_HEADING_MIN = 8'sd1;
	localparam logic signed [7:0] CODE_HEADING_MAX = 8'sd99;
	localparam logic signed [7:0] CODE_FREE        = 8'sd0;
	localparam logic signed [7:0] CODE_UNKNOWN     = -8'sd1;

	// Decision source codes
	localparam logic [2:0] SRC_OBSTACLE = 3'd0;
	localparam logic [2:0] SRC_CENTER   = 3'd1;
	localparam logic [2:0] SRC_MEAN     = 3'd2;
	localparam logic [2:0] SRC_FREE     = 3'd3;
	localparam logic [2:0] SRC_UNKNOWN  = 3'd4;

	localparam int TRIG_FRAC_BITS    = 14;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int TABLE_STEPS       = 30;
	localparam int CORD_N = (CORDIC_ITERATIONS < TABLE_STEPS) ? CORDIC_ITERATIONS : TABLE_STEPS;

	localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
	localparam int SUM_W   = 24;
	localparam int XY_W    = SUM_W + 4;     // room for CORDIC gain and sqrt(2)
	localparam int ITER_W  = 5;
	localparam int TAB_N   = 100;
	localparam int TAB_IDX_W = 7;
	localparam int TRIG_SH = 30 - TRIG_FRAC_BITS;
	localparam longint TABLE_GAIN_Q30 = 64'sd652032874;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	typedef logic signed [TRIG_W-1:0] trig_tab_t [0:TAB_N-1];
	typedef logic [31:0] atan_tab_t [0:(1<<ITER_W)-1];

	// atan(2^-i) in fractions of a turn, 2^32 per turn; unused tail is zero
	localparam atan_tab_t TURN_ATAN = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
		32'd0, 32'd0
	};

	// Builds sin or cos of k/100 turn, evaluated at elaboration only
	function automatic trig_tab_t build_trig(input bit want_sin);
		trig_tab_t tab;
		logic [31:0] a;
		logic [31:0] q;
		logic [31:0] r32;
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint c;
		longint s;
		longint v;
		for (int k = 0; k < TAB_N; k++) begin
			a = 32'((longint'(k) * 64'sd4294967296 + 64'sd50) / 64'sd100);
			q = ((a + (QUARTER_TURN >> 1)) >> 30) & 32'd3;
			r32 = a - q * QUARTER_TURN;
			z = longint'($signed(r32));
			x = TABLE_GAIN_Q30;
			y = 0;
			for (int i = 0; i < TABLE_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - longint'(TURN_ATAN[i]);
				end else begin
					x = x + dx; y = y - dy; z = z + longint'(TURN_ATAN[i]);
				end
			end
			case (q[1:0])
				2'd0: begin c = x;  s = y;  end
				2'd1: begin c = -y; s = x;  end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			v = want_sin ? s : c;
			v = (v + (longint'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
			tab[k] = TRIG_W'(v);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_trig(1'b1);
	localparam trig_tab_t COS_TAB = build_trig(1'b0);

endpackage

`default_nettype wire

// ===== src/direction_grid_block_downsampler_top.sv =====
// Top level: block accumulation, decision and iterative CORDIC for the mean heading.
//
//  channel | ports                                       | flow
//  --------+---------------------------------------------+------
//  in      | in_valid, in_stall, cell_value, is_center,  | in
//          | last_in_block                               |
//  out     | out_valid, out_stall, out_value,            | out
//          | decision_source                             |
//
// One cell per cycle while accumulating. A block that falls to the circular mean
// passes through the shared CORDIC rotator (S_CORD) and then the encode state
// (S_EMIT) before its result is loaded; other blocks load it directly from S_ACC.
// Input stalls in S_CORD and S_EMIT, and a last cell stalls while the output
// register holds an untaken result. Reset clears all flags and sums.
`default_nettype none

module direction_grid_block_downsampler_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [7:0] cell_value,
	input  wire logic              is_center,
	input  wire logic              last_in_block,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [7:0]      out_value,
	output logic [2:0]             decision_source
);

	typedef enum logic [1:0] {S_ACC, S_CORD, S_EMIT} state_t;

	state_t state_q;
	logic obstacle_q, free_q, heading_q;
	logic signed [7:0] center_q;
	logic [dgbd_pkg::SUM_W-1:0] sin_sum_q, cos_sum_q;
	logic out_valid_q;
	logic signed [7:0] out_value_q;
	logic [2:0] src_q;
	logic [dgbd_pkg::ITER_W-1:0] iter_q;
	logic signed [dgbd_pkg::XY_W-1:0] x_q, y_q;
	logic [31:0] z_q;

	// Cell classification and accumulation of the current item
	logic acc_fire, is_obs, is_head, is_free, center_head, out_free;
	logic obs_n, free_n, head_n;
	logic go_cord, out_load;
	logic signed [7:0] center_n;
	logic [dgbd_pkg::TAB_IDX_W-1:0] tab_idx;
	logic [dgbd_pkg::SUM_W-1:0] sin_n, cos_n;

	assign in_stall = (state_q != S_ACC) || (last_in_block && out_valid_q && out_stall);
	assign acc_fire = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign is_obs  = cell_value == dgbd_pkg::CODE_OBSTACLE;
	assign is_head = (cell_value >= dgbd_pkg::CODE_HEADING_MIN)
		&& (cell_value <= dgbd_pkg::CODE_HEADING_MAX);
	assign is_free = cell_value == dgbd_pkg::CODE_FREE;
	assign tab_idx = is_head ? cell_value[dgbd_pkg::TAB_IDX_W-1:0] : '0;

	always_comb begin
		obs_n    = obstacle_q | is_obs;
		free_n   = free_q | is_free;
		head_n   = heading_q | is_head;
		center_n = is_center ? cell_value : center_q;
		sin_n    = sin_sum_q;
		cos_n    = cos_sum_q;
		if (is_head) begin
			sin_n = sin_sum_q + dgbd_pkg::SUM_W'(dgbd_pkg::SIN_TAB[tab_idx]);
			cos_n = cos_sum_q + dgbd_pkg::SUM_W'(dgbd_pkg::COS_TAB[tab_idx]);
		end
	end

	assign center_head = (center_n >= dgbd_pkg::CODE_HEADING_MIN)
		&& (center_n <= dgbd_pkg::CODE_HEADING_MAX);

	// mean heading needed: no obstacle, no center heading, some heading seen
	assign go_cord  = !obs_n && !center_head && head_n;
	assign out_load = ((state_q == S_ACC) && acc_fire && last_in_block && !go_cord)
		|| ((state_q == S_EMIT) && out_free);

	// CORDIC vectoring step, shared over all iterations
	logic signed [dgbd_pkg::XY_W-1:0] dx, dy, x0, y0;
	logic [31:0] step_atan;
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign step_atan = dgbd_pkg::TURN_ATAN[iter_q];
	assign x0 = dgbd_pkg::XY_W'($signed(cos_n));
	assign y0 = dgbd_pkg::XY_W'($signed(sin_n));

	// enc = (z * 100 + half turn) >> 32, clamped to the heading range
	logic [38:0] enc_prod;
	logic [6:0] enc_raw;
	logic signed [7:0] enc_code;
	assign enc_prod = {1'b0, z_q, 6'b0} + {2'b0, z_q, 5'b0} + {5'b0, z_q, 2'b0}
		+ {7'b0, dgbd_pkg::HALF_TURN};
	assign enc_raw = enc_prod[38:32];
	always_comb begin
		if (enc_raw == 7'd0)
			enc_code = dgbd_pkg::CODE_HEADING_MIN;
		else if (enc_raw > 7'(dgbd_pkg::CODE_HEADING_MAX))
			enc_code = dgbd_pkg::CODE_HEADING_MAX;
		else
			enc_code = signed'({1'b0, enc_raw});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ACC;
			obstacle_q  <= 1'b0;
			free_q      <= 1'b0;
			heading_q   <= 1'b0;
			center_q    <= dgbd_pkg::CODE_UNKNOWN;
			sin_sum_q   <= '0;
			cos_sum_q   <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= dgbd_pkg::CODE_UNKNOWN;
			src_q       <= dgbd_pkg::SRC_UNKNOWN;
			iter_q      <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_ACC: begin
					if (acc_fire) begin
						if (last_in_block) begin
							obstacle_q <= 1'b0;
							free_q     <= 1'b0;
							heading_q  <= 1'b0;
							center_q   <= dgbd_pkg::CODE_UNKNOWN;
							sin_sum_q  <= '0;
							cos_sum_q  <= '0;
							if (go_cord) begin
								iter_q  <= '0;
								state_q <= S_CORD;
							end else begin
								if (obs_n) begin
									out_value_q <= dgbd_pkg::CODE_OBSTACLE;
									src_q       <= dgbd_pkg::SRC_OBSTACLE;
								end else if (center_head) begin
									out_value_q <= center_n;
									src_q       <= dgbd_pkg::SRC_CENTER;
								end else if (free_n) begin
									out_value_q <= dgbd_pkg::CODE_FREE;
									src_q       <= dgbd_pkg::SRC_FREE;
								end else begin
									out_value_q <= dgbd_pkg::CODE_UNKNOWN;
									src_q       <= dgbd_pkg::SRC_UNKNOWN;
								end
							end
						end else begin
							obstacle_q <= obs_n;
							free_q     <= free_n;
							heading_q  <= head_n;
							center_q   <= center_n;
							sin_sum_q  <= sin_n;
							cos_sum_q  <= cos_n;
						end
					end
				end
				S_CORD: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == dgbd_pkg::ITER_W'(dgbd_pkg::CORD_N - 1))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_value_q <= enc_code;
						src_q       <= dgbd_pkg::SRC_MEAN;
						state_q     <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	// CORDIC working registers
	always_ff @(posedge clk) begin
		if (state_q == S_ACC) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= dgbd_pkg::HALF_TURN;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (state_q == S_CORD) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_atan;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_atan;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign decision_source = src_q;

`ifndef ASSERT_OFF
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ACC) |-> in_stall)
		else $error("input taken while CORDIC busy");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD) |-> (iter_q < dgbd_pkg::ITER_W'(dgbd_pkg::CORD_N)))
		else $error("CORDIC iteration count out of range");
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && src_q == dgbd_pkg::SRC_MEAN) |->
		(out_value_q >= dgbd_pkg::CODE_HEADING_MIN && out_value_q <= dgbd_pkg::CODE_HEADING_MAX))
		else $error("mean heading outside 1..99");
	a_obstacle_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && src_q == dgbd_pkg::SRC_OBSTACLE) |->
		(out_value_q == dgbd_pkg::CODE_OBSTACLE))
		else $error("obstacle source with wrong code");
	a_emit_after_cord: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_EMIT) |-> $past(state_q == S_CORD))
		else $error("encode entered without CORDIC pass");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the direction grid block downsampler.
`timescale 1ns / 100ps

module testbench;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_CELLS    = 150;
	localparam int OVERLONG_CELLS = 600;
	localparam int MEAN_STEPS     = (dgbd_pkg::CORDIC_ITERATIONS < 30)
		? dgbd_pkg::CORDIC_ITERATIONS : 30;
	localparam int ROUND_SHIFT    = 30 - dgbd_pkg::TRIG_FRAC_BITS;

	typedef struct packed {
		logic signed [7:0] value;
		logic              center;
		logic              last;
	} cell_item_t;

	typedef struct packed {
		logic signed [7:0] code;
		logic [2:0]        src;
	} code_result_t;

	typedef enum int {K_OBST, K_HEAD, K_FREE, K_ODD} cell_kind_t;
	typedef enum int {BLK_MEAN, BLK_CENTER, BLK_QUIET, BLK_OBST, BLK_NOISE} block_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic signed [7:0] cell_value = '0;
	logic              is_center = 1'b0;
	logic              last_in_block = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [7:0] out_value;
	logic [2:0]        decision_source;

	direction_grid_block_downsampler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_value(cell_value),
		.is_center(is_center),
		.last_in_block(last_in_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_value(out_value),
		.decision_source(decision_source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cell_item_t   pending_cells[$];
	code_result_t expected_codes[$];
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	bit           hold_go = 1'b0;
	int           mismatches = 0;

	// predictor state
	logic [31:0]       step_turn [30];
	int                sin_q [100];
	int                cos_q [100];
	bit                obst_seen;
	bit                free_seen;
	bit                head_seen;
	logic signed [7:0] blk_center;
	logic [23:0]       sine_acc;
	logic [23:0]       cosine_acc;

	// sin/cos of k/100 turn, rotation CORDIC on the residual after quarter-turn reduction
	function automatic void build_trig_tables();
		logic [63:0] a64;
		logic [31:0] a;
		logic [31:0] t;
		logic [31:0] r;
		logic [1:0]  q;
		longint      z;
		longint      x;
		longint      y;
		longint      dx;
		longint      dy;
		longint      c;
		longint      s;
		step_turn = '{
			32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
			32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
			32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
			32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
			32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
			32'd20, 32'd10, 32'd5, 32'd3, 32'd1
		};
		for (int k = 0; k < 100; k++) begin
			a64 = (64'(k) * 64'h1_0000_0000 + 64'd50) / 64'd100;
			a = a64[31:0];
			t = a + 32'h2000_0000;
			q = t[31:30];
			r = a - {q, 30'd0};
			z = longint'($signed(r));
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - longint'(step_turn[i]);
				end else begin
					x = x + dx; y = y - dy; z = z + longint'(step_turn[i]);
				end
			end
			case (q)
				2'd0: begin c = x;  s = y;  end
				2'd1: begin c = -y; s = x;  end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			cos_q[k] = int'((c + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
			sin_q[k] = int'((s + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
		end
	endfunction

	function automatic void clear_block();
		obst_seen = 1'b0;
		free_seen = 1'b0;
		head_seen = 1'b0;
		blk_center = dgbd_pkg::CODE_UNKNOWN;
		sine_acc = '0;
		cosine_acc = '0;
	endfunction

	// vectoring CORDIC on the sums, angle in 2^32 per turn, encoded to 1..99
	function automatic logic signed [7:0] heading_mean_code();
		longint      x;
		longint      y;
		longint      dx;
		longint      dy;
		longint      enc;
		logic [31:0] ang;
		logic [63:0] prod;
		x = longint'($signed(cosine_acc));
		y = longint'($signed(sine_acc));
		ang = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = 32'h8000_0000;
		end
		for (int i = 0; i < MEAN_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; ang = ang + step_turn[i];
			end else begin
				x = x - dx; y = y + dy; ang = ang - step_turn[i];
			end
		end
		prod = {32'd0, ang} * 64'd100 + 64'h8000_0000;
		enc = longint'(prod >> 32);
		if (enc < 1) enc = 1;
		if (enc > 99) enc = 99;
		return 8'(enc);
	endfunction

	function automatic bit absorb_cell(input cell_item_t c, output code_result_t res);
		int idx;
		idx = int'(c.value);
		if (c.value == dgbd_pkg::CODE_OBSTACLE) begin
			obst_seen = 1'b1;
		end else if (c.value >= dgbd_pkg::CODE_HEADING_MIN
			&& c.value <= dgbd_pkg::CODE_HEADING_MAX) begin
			head_seen = 1'b1;
			sine_acc = sine_acc + 24'(sin_q[idx]);
			cosine_acc = cosine_acc + 24'(cos_q[idx]);
		end else if (c.value == dgbd_pkg::CODE_FREE) begin
			free_seen = 1'b1;
		end
		if (c.center) blk_center = c.value;
		if (!c.last) return 1'b0;
		if (obst_seen) begin
			res = '{dgbd_pkg::CODE_OBSTACLE, dgbd_pkg::SRC_OBSTACLE};
		end else if (blk_center >= dgbd_pkg::CODE_HEADING_MIN
			&& blk_center <= dgbd_pkg::CODE_HEADING_MAX) begin
			res = '{blk_center, dgbd_pkg::SRC_CENTER};
		end else if (head_seen) begin
			res = '{heading_mean_code(), dgbd_pkg::SRC_MEAN};
		end else if (free_seen) begin
			res = '{dgbd_pkg::CODE_FREE, dgbd_pkg::SRC_FREE};
		end else begin
			res = '{dgbd_pkg::CODE_UNKNOWN, dgbd_pkg::SRC_UNKNOWN};
		end
		clear_block();
		return 1'b1;
	endfunction

	// ---------------- driver ----------------
	cell_item_t   cur_cell;
	cell_item_t   next_cell;
	code_result_t block_code;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				cur_cell = {cell_value, is_center, last_in_block};
				if (absorb_cell(cur_cell, block_code))
					expected_codes.insert(expected_codes.size(), block_code);
			end
			if (!in_valid || !in_stall) begin
				if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cell = pending_cells.pop_front();
					in_valid <= 1'b1;
					cell_value <= next_cell.value;
					is_center <= next_cell.center;
					last_in_block <= next_cell.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor and receiver ----------------
	bit           hold_taken = 1'b0;
	int           hold_left = 0;
	code_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_codes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: value %0d source %0d",
							out_value, decision_source);
				end else begin
					want = expected_codes.pop_front();
					if (out_value !== want.code || decision_source !== want.src) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0d got %0d/%0d",
								want.code, want.src, out_value, decision_source);
					end
				end
			end
			if (hold_go && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ---------------- watchdog ----------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic push_cell(input logic signed [7:0] v, input bit c, input bit l);
		cell_item_t item;
		item = '{v, c, l};
		pending_cells.insert(pending_cells.size(), item);
	endtask

	function automatic logic signed [7:0] pick_code(input cell_kind_t kind);
		int r;
		case (kind)
			K_OBST: return dgbd_pkg::CODE_OBSTACLE;
			K_HEAD: return 8'($urandom_range(1, 99));
			K_FREE: return dgbd_pkg::CODE_FREE;
			default: begin
				// unlisted: -128..-1 or 101..127
				r = $urandom_range(0, 154);
				if (r < 128) return 8'(-(r + 1));
				return 8'(101 + (r - 128));
			end
		endcase
	endfunction

	task automatic add_block(input block_mode_t mode, input int len, inout int count);
		int                cpos;
		int                dup;
		int                r;
		bit                c;
		bit                l;
		cell_kind_t        kind;
		logic signed [7:0] v;
		cpos = $urandom_range(0, len);      // len means no center mark
		dup = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
		for (int k = 0; k < len; k++) begin
			c = (k == cpos) || (k == dup);
			r = $urandom_range(0, 99);
			case (mode)
				BLK_MEAN:
					kind = c ? ((r < 50) ? K_FREE : K_ODD)
						: ((r < 70) ? K_HEAD : (r < 85) ? K_FREE : K_ODD);
				BLK_CENTER:
					kind = (k == cpos) ? K_HEAD
						: ((r < 60) ? K_HEAD : (r < 80) ? K_FREE : K_ODD);
				BLK_QUIET:
					kind = (r < 40) ? K_FREE : K_ODD;
				default:
					kind = (r < 20) ? K_OBST : (r < 70) ? K_HEAD : (r < 85) ? K_FREE : K_ODD;
			endcase
			v = (mode == BLK_NOISE) ? 8'($urandom_range(0, 255)) : pick_code(kind);
			// now and then the end mark is dropped and the block runs on
			l = (k == len - 1) && ($urandom_range(0, 19) != 0);
			push_cell(v, c, l);
			count++;
		end
	endtask

	int          phase_count;
	int          len;
	int          pick;
	block_mode_t mode;

	initial begin
		build_trig_tables();
		clear_block();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed blocks
		push_cell(dgbd_pkg::CODE_OBSTACLE, 0, 1);
		push_cell(dgbd_pkg::CODE_FREE, 0, 1);
		push_cell(-8'sd128, 0, 1);
		push_cell(8'sd127, 0, 1);
		push_cell(dgbd_pkg::CODE_UNKNOWN, 0, 1);
		push_cell(8'sd5, 0, 0);
		push_cell(8'sd50, 1, 0);
		push_cell(8'sd99, 0, 1);
		push_cell(dgbd_pkg::CODE_FREE, 1, 0);   // center that is no heading
		push_cell(8'sd1, 0, 0);
		push_cell(8'sd99, 0, 1);
		push_cell(8'sd10, 1, 0);                // later center mark wins
		push_cell(8'sd20, 1, 1);
		push_cell(8'sd25, 0, 0);                // opposite headings, zero vector
		push_cell(8'sd75, 0, 1);
		push_cell(8'sd40, 1, 0);                // obstacle beats center heading
		push_cell(dgbd_pkg::CODE_OBSTACLE, 0, 0);
		push_cell(dgbd_pkg::CODE_FREE, 0, 1);
		push_cell(dgbd_pkg::CODE_UNKNOWN, 1, 0);
		push_cell(8'sd30, 0, 0);
		push_cell(dgbd_pkg::CODE_FREE, 0, 1);
		push_cell(8'sd50, 0, 0);                // mean in the left half plane
		push_cell(dgbd_pkg::CODE_FREE, 0, 0);
		push_cell(-8'sd5, 0, 1);

		// sender pause until every result is back
		while (pending_cells.size() != 0 || in_valid || expected_codes.size() != 0)
			@(posedge clk);
		@(negedge clk);

		// overlong block: cosine sum overflows the signed 24-bit range
		for (int k = 0; k < OVERLONG_CELLS; k++)
			push_cell(8'($urandom_range(1, 3)), 1'b0, k == OVERLONG_CELLS - 1);

		for (int ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			phase_count = 0;
			while (phase_count < PHASE_CELLS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 9);
				pick = $urandom_range(0, 9);
				mode = (pick < 4) ? BLK_MEAN : (pick < 6) ? BLK_CENTER
					: (pick < 7) ? BLK_QUIET : (pick < 9) ? BLK_OBST : BLK_NOISE;
				add_block(mode, len, phase_count);
			end
			if (ph == 0) hold_go = 1'b1;   // long output hold while input keeps coming
			while (pending_cells.size() != 0) @(posedge clk);
		end
		@(negedge clk);
		push_cell(dgbd_pkg::CODE_FREE, 0, 1);   // close any block left open

		while (pending_cells.size() != 0 || in_valid) @(posedge clk);
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_codes.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
